// ===== rtl/cdr_pkg.sv =====
package cdr_pkg;

	// command codes
	localparam logic [3:0] MODE_READ       = 4'd0;
	localparam logic [3:0] MODE_NEXT_DAY   = 4'd1;
	localparam logic [3:0] MODE_PREV_DAY   = 4'd2;
	localparam logic [3:0] MODE_SET_DAY    = 4'd3;
	localparam logic [3:0] MODE_SET_MONTH  = 4'd4;
	localparam logic [3:0] MODE_SET_YEAR   = 4'd5;
	localparam logic [3:0] MODE_SET_HOUR   = 4'd6;
	localparam logic [3:0] MODE_SET_MINUTE = 4'd7;
	localparam logic [3:0] MODE_LOAD_ALL   = 4'd8;

	localparam logic [11:0] YEAR_MIN   = 12'd1970;
	localparam logic [11:0] YEAR_MAX   = 12'd2100;
	localparam logic [4:0]  HOUR_MAX   = 5'd23;
	localparam logic [5:0]  MINUTE_MAX = 6'd59;
	localparam logic [3:0]  MONTH_JAN  = 4'd1;
	localparam logic [3:0]  MONTH_FEB  = 4'd2;
	localparam logic [3:0]  MONTH_DEC  = 4'd12;
	localparam logic [4:0]  DAY_FIRST  = 5'd1;

	// multiplicative inverse of 25 modulo 4096; y is a multiple of 25
	// exactly when y * INV25 mod 4096 stays at or below 4095 / 25
	localparam logic [11:0] INV25     = 12'd3113;
	localparam logic [11:0] DIV25_LIM = 12'd163;

	typedef struct packed {
		logic [3:0]  mode;
		logic [4:0]  new_day;
		logic [3:0]  new_month;
		logic [11:0] new_year;
		logic [4:0]  new_hour;
		logic [5:0]  new_minute;
	} cdr_cmd_t;

	typedef struct packed {
		logic [4:0]  day_out;
		logic [3:0]  month_out;
		logic [11:0] year_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic        rejected;
	} cdr_res_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} cdr_date_t;

	localparam cdr_date_t DATE_RESET = '{
		day:    5'd1,
		month:  4'd1,
		year:   12'd1970,
		hour:   5'd0,
		minute: 6'd0
	};

	// Gregorian rule: y % 4 == 0 and (y % 25 != 0 or y % 16 == 0)
	function automatic logic is_leap(input logic [11:0] y);
		logic [11:0] prod;
		logic        div25;
		// keep only the product modulo 4096
		prod  = y * INV25;
		div25 = (prod <= DIV25_LIM);
		return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

	// month length, zero for a month code outside January to December
	function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
			4'd2:                                         n = leap ? 5'd29 : 5'd28;
			default:                                      n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/cdr_step.sv =====
module cdr_step
	import cdr_pkg::*;
(
	input  cdr_cmd_t  cmd,
	input  cdr_date_t cur,
	output cdr_date_t nxt,
	output logic      rejected
);

	logic       leap_cur;
	logic       leap_new;
	logic [4:0] dim_cur;
	logic [4:0] dim_prev;
	logic [4:0] dim_set_month;
	logic [4:0] dim_set_year;
	logic [4:0] dim_load;
	logic       year_ok;
	logic       month_ok;
	logic       hour_ok;
	logic       minute_ok;
	logic       load_ok;

	assign leap_cur      = is_leap(cur.year);
	assign leap_new      = is_leap(cmd.new_year);
	assign dim_cur       = days_in(cur.month, leap_cur);
	assign dim_prev      = days_in(cur.month - 4'd1, leap_cur);
	assign dim_set_month = days_in(cmd.new_month, leap_cur);
	assign dim_set_year  = days_in(cur.month, leap_new);
	assign dim_load      = days_in(cmd.new_month, leap_new);

	assign year_ok   = (cmd.new_year >= YEAR_MIN) && (cmd.new_year <= YEAR_MAX);
	assign month_ok  = (cmd.new_month >= MONTH_JAN) && (cmd.new_month <= MONTH_DEC);
	assign hour_ok   = (cmd.new_hour <= HOUR_MAX);
	assign minute_ok = (cmd.new_minute <= MINUTE_MAX);
	assign load_ok   = year_ok && month_ok && hour_ok && minute_ok &&
		(cmd.new_day >= DAY_FIRST) && (cmd.new_day <= dim_load);

	always_comb begin
		nxt      = cur;
		rejected = 1'b0;
		unique case (cmd.mode)
			MODE_NEXT_DAY: begin
				if (cur.day < dim_cur) begin
					nxt.day = cur.day + 5'd1;
				end else begin
					nxt.day = DAY_FIRST;
					if (cur.month < MONTH_DEC) begin
						nxt.month = cur.month + 4'd1;
					end else begin
						nxt.month = MONTH_JAN;
						nxt.year  = cur.year + 12'd1;
					end
				end
			end
			MODE_PREV_DAY: begin
				if (cur.day > DAY_FIRST) begin
					nxt.day = cur.day - 5'd1;
				end else if (cur.month > MONTH_JAN) begin
					nxt.month = cur.month - 4'd1;
					nxt.day   = dim_prev;
				end else begin
					nxt.month = MONTH_DEC;
					nxt.year  = cur.year - 12'd1;
					nxt.day   = days_in(MONTH_DEC, 1'b0);
				end
			end
			MODE_SET_DAY: begin
				if ((cmd.new_day >= DAY_FIRST) && (cmd.new_day <= dim_cur))
					nxt.day = cmd.new_day;
				else
					rejected = 1'b1;
			end
			MODE_SET_MONTH: begin
				if (month_ok) begin
					nxt.month = cmd.new_month;
					if (cur.day > dim_set_month)
						nxt.day = dim_set_month;
				end else begin
					rejected = 1'b1;
				end
			end
			MODE_SET_YEAR: begin
				if (year_ok) begin
					nxt.year = cmd.new_year;
					if (cur.day > dim_set_year)
						nxt.day = dim_set_year;
				end else begin
					rejected = 1'b1;
				end
			end
			MODE_SET_HOUR: begin
				if (hour_ok)
					nxt.hour = cmd.new_hour;
				else
					rejected = 1'b1;
			end
			MODE_SET_MINUTE: begin
				if (minute_ok)
					nxt.minute = cmd.new_minute;
				else
					rejected = 1'b1;
			end
			MODE_LOAD_ALL: begin
				if (load_ok) begin
					nxt.day    = cmd.new_day;
					nxt.month  = cmd.new_month;
					nxt.year   = cmd.new_year;
					nxt.hour   = cmd.new_hour;
					nxt.minute = cmd.new_minute;
				end else begin
					rejected = 1'b1;
				end
			end
			default: begin
				// read and unused codes: hold everything
			end
		endcase
	end

endmodule

// ===== rtl/calendar_date_register_core.sv =====
// Channel   Direction  Handshake             Word
// cmd       in         cmd_valid, cmd_stall  cdr_cmd_t (mode and new field values)
// res       out        res_valid, res_stall  cdr_res_t (date and time, rejected)
//
// One command word per cycle, sustained while no res stall is held. A word is held in the
// input register (cmd_s1), and its result then lands in the output register (res_q,
// res_valid) once that register is free. Each command needs the date left by the one
// before, and that single combinational update sets the rate.
// Reset (arst_n low) gives 01.01.1970 00:00 and empties both registers.
// A res stall backs up into the input register; cmd_stall rises only then.
module calendar_date_register_core
	import cdr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  cdr_cmd_t cmd,
	output logic     res_valid,
	input  logic     res_stall,
	output cdr_res_t res
);

	cdr_cmd_t  cmd_s1;
	logic      cmd_valid_s1;
	cdr_date_t date_q;
	cdr_res_t  res_q;
	logic      res_valid_q;

	cdr_date_t date_nxt;
	logic      rej_nxt;
	logic      advance;
	logic      fire;

	// output register is free when empty or being drained this cycle
	assign advance   = !res_valid_q || !res_stall;
	assign fire      = cmd_valid_s1 && advance;
	// hold off new words only while the input register is stuck
	assign cmd_stall = cmd_valid_s1 && !advance;

	// capture the incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// apply one command to the date registers
	cdr_step u_step (
		.cmd      (cmd_s1),
		.cur      (date_q),
		.nxt      (date_nxt),
		.rejected (rej_nxt)
	);

	// advance the date state only when the result can be stored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_q <= DATE_RESET;
		end else if (fire) begin
			date_q <= date_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			// drop the word once taken
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= '{
				day_out:    date_nxt.day,
				month_out:  date_nxt.month,
				year_out:   date_nxt.year,
				hour_out:   date_nxt.hour,
				minute_out: date_nxt.minute,
				rejected:   rej_nxt
			};
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// a pending result always mirrors the date state it left behind
	a_res_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.day_out == date_q.day) &&
			(res_q.month_out == date_q.month) && (res_q.year_out == date_q.year) &&
			(res_q.hour_out == date_q.hour) && (res_q.minute_out == date_q.minute))
		else $error("result word differs from date state");

	// a rejected command leaves the date untouched
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rej_nxt |=> $stable(date_q))
		else $error("rejected command changed the date");

	// month stays in January to December and day stays at or above one
	a_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(date_q.month >= MONTH_JAN) && (date_q.month <= MONTH_DEC) &&
		(date_q.day >= DAY_FIRST))
		else $error("date state out of range");

	// the input register never drops a word while the output is blocked
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid_s1 && !advance |=> cmd_valid_s1 && $stable(cmd_s1))
		else $error("input register lost a stalled word");
`endif

endmodule
